// ===== rtl/mvs_pkg.sv =====
package mvs_pkg;

   localparam int PENDING_BITS_DEF = 34;
   localparam int LENGTH_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);

   // status codes carried on rsp_tuser
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;
   localparam logic [1:0] ST_OVF   = 2'd3;

   // length kinds for multi-byte headers
   localparam logic [1:0] HK_STR   = 2'd0;
   localparam logic [1:0] HK_EXT   = 2'd1;
   localparam logic [1:0] HK_ARRAY = 2'd2;
   localparam logic [1:0] HK_MAP   = 2'd3;

   typedef enum logic [1:0] {
      PH_MARK = 2'd0,
      PH_HEAD = 2'd1,
      PH_PAY  = 2'd2,
      PH_DROP = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_SIMPLE = 3'd0,
      ACT_PEND   = 3'd1,
      ACT_PAY    = 3'd2,
      ACT_HEAD   = 3'd3,
      ACT_BAD    = 3'd4
   } action_type;

   typedef struct packed {
      action_type act;
      logic [4:0] n;          // pending increment or fixed payload length
      logic [2:0] hdr_bytes;
      logic [1:0] hdr_kind;
   } marker_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       eob;
      marker_type mark;
   } item_type;

   function automatic logic [4:0] fixed_len(input logic [7:0] m);
      logic [4:0] r;
      case (m)
         8'hCA: r = 5'd4;
         8'hCB: r = 5'd8;
         8'hCC: r = 5'd1;
         8'hCD: r = 5'd2;
         8'hCE: r = 5'd4;
         8'hCF: r = 5'd8;
         8'hD0: r = 5'd1;
         8'hD1: r = 5'd2;
         8'hD2: r = 5'd4;
         8'hD3: r = 5'd8;
         8'hD4: r = 5'd2;
         8'hD5: r = 5'd3;
         8'hD6: r = 5'd5;
         8'hD7: r = 5'd9;
         8'hD8: r = 5'd17;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic marker_type decode_marker(input logic [7:0] m);
      marker_type d;
      d.act       = ACT_SIMPLE;
      d.n         = 5'd0;
      d.hdr_bytes = 3'd0;
      d.hdr_kind  = HK_STR;
      if (m < 8'h80 || m >= 8'hE0 || m == 8'hC0 || m == 8'hC2 || m == 8'hC3) begin
         d.act = ACT_SIMPLE;
      end else if (m <= 8'h8F) begin
         d.act = ACT_PEND;
         d.n   = {m[3:0], 1'b0};
      end else if (m <= 8'h9F) begin
         d.act = ACT_PEND;
         d.n   = {1'b0, m[3:0]};
      end else if (m <= 8'hBF) begin
         d.act = ACT_PAY;
         d.n   = m[4:0];
      end else if (m >= 8'hCA && m <= 8'hD8) begin
         d.act = ACT_PAY;
         d.n   = fixed_len(m);
      end else begin
         d.act = ACT_HEAD;
         case (m)
            8'hC4, 8'hD9: begin d.hdr_bytes = 3'd1; d.hdr_kind = HK_STR;   end
            8'hC5, 8'hDA: begin d.hdr_bytes = 3'd2; d.hdr_kind = HK_STR;   end
            8'hC6, 8'hDB: begin d.hdr_bytes = 3'd4; d.hdr_kind = HK_STR;   end
            8'hC7:        begin d.hdr_bytes = 3'd1; d.hdr_kind = HK_EXT;   end
            8'hC8:        begin d.hdr_bytes = 3'd2; d.hdr_kind = HK_EXT;   end
            8'hC9:        begin d.hdr_bytes = 3'd4; d.hdr_kind = HK_EXT;   end
            8'hDC:        begin d.hdr_bytes = 3'd2; d.hdr_kind = HK_ARRAY; end
            8'hDD:        begin d.hdr_bytes = 3'd4; d.hdr_kind = HK_ARRAY; end
            8'hDE:        begin d.hdr_bytes = 3'd2; d.hdr_kind = HK_MAP;   end
            8'hDF:        begin d.hdr_bytes = 3'd4; d.hdr_kind = HK_MAP;   end
            default:      d.act = ACT_BAD;
         endcase
      end
      return d;
   endfunction

endpackage

// ===== rtl/mvs_front.sv =====
module mvs_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // end_of_buffer
   input  logic              queue_full,
   output logic              push,
   output mvs_pkg::item_type push_item
);
   import mvs_pkg::*;

   // every byte is classified as if it were a marker; the back end
   // ignores the decode when it is in a header or payload phase
   assign req_tready          = !queue_full;
   assign push                = req_tvalid && !queue_full;
   assign push_item.data_byte = req_tdata;
   assign push_item.eob       = req_tlast;
   assign push_item.mark      = decode_marker(req_tdata);

endmodule

// ===== rtl/mvs_queue.sv =====
module mvs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mvs_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output mvs_pkg::item_type pop_item
);
   import mvs_pkg::*;

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/mvs_back.sv =====
module mvs_back #(
   parameter int PENDING_BITS = mvs_pkg::PENDING_BITS_DEF,
   parameter int LENGTH_BITS  = mvs_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  mvs_pkg::item_type item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] value_bytes
   output logic [1:0]        rsp_tuser,   // [1:0] status
   output logic              rsp_tlast    // at_buffer_end
);
   import mvs_pkg::*;

   localparam int PB   = PENDING_BITS;
   localparam int LB   = LENGTH_BITS;
   localparam int PAYW = LB + 1;
   localparam int SUMW = ((PB > LB + 1) ? PB : LB + 1) + 1;

   phase_type         phase_ff, phase_in;
   logic [2:0]        hdr_left_ff, hdr_left_in;
   logic [1:0]        hdr_kind_ff, hdr_kind_in;
   logic [31:0]       hdr_acc_ff, hdr_acc_in;
   logic [PAYW-1:0]   pay_left_ff, pay_left_in;
   logic [PB-1:0]     pend_ff, pend_in;
   logic [31:0]       bcnt_ff, bcnt_in;

   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_bytes_ff;
   logic [1:0]        out_status_ff;
   logic              out_last_ff;

   logic              res_valid;
   logic [1:0]        res_status;
   logic [31:0]       res_bytes;

   assign pop        = item_valid && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_bytes_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      logic [31:0]     bc_n;
      logic [PB-1:0]   pend_dec;
      logic [SUMW-1:0] base;
      logic [SUMW-1:0] addend;
      logic [SUMW-1:0] sum;
      logic            sum_ovf;
      logic [31:0]     acc_n;
      logic [2:0]      left_n;
      logic            too_long;
      logic [LB-1:0]   len;
      logic [PAYW-1:0] hdr_pay;
      logic [1:0]      err;

      phase_in    = phase_ff;
      hdr_left_in = hdr_left_ff;
      hdr_kind_in = hdr_kind_ff;
      hdr_acc_in  = hdr_acc_ff;
      pay_left_in = pay_left_ff;
      pend_in     = pend_ff;
      bcnt_in     = bcnt_ff;
      res_valid   = 1'b0;
      res_status  = ST_OK;
      err         = ST_OK;

      bc_n     = (&bcnt_ff) ? bcnt_ff : bcnt_ff + 32'd1;
      pend_dec = (pend_ff != '0) ? pend_ff - {{(PB-1){1'b0}}, 1'b1} : pend_ff;
      acc_n    = {hdr_acc_ff[23:0], item.data_byte};
      left_n   = (hdr_left_ff != 3'd0) ? hdr_left_ff - 3'd1 : 3'd0;
      too_long = (({1'b0, acc_n} >> LB) != 33'd0);
      len      = acc_n[LB-1:0];
      hdr_pay  = (hdr_kind_ff == HK_EXT) ? {1'b0, len} + PAYW'(1) : {1'b0, len};

      // one shared adder for the pending count
      if (phase_ff == PH_MARK) begin
         base   = SUMW'(pend_dec);
         addend = SUMW'(item.mark.n);
      end else begin
         base   = SUMW'(pend_ff);
         addend = (hdr_kind_ff == HK_MAP) ? SUMW'({len, 1'b0}) : SUMW'({1'b0, len});
      end
      sum     = base + addend;
      sum_ovf = (sum[SUMW-1:PB] != '0);

      if (pop) begin
         if (phase_ff == PH_DROP) begin
            if (item.eob) begin
               phase_in    = PH_MARK;
               hdr_left_in = '0;
               hdr_kind_in = '0;
               hdr_acc_in  = '0;
               pay_left_in = '0;
               pend_in     = '0;
               bcnt_in     = '0;
            end
         end else begin
            bcnt_in = bc_n;
            case (phase_ff)
               PH_MARK: begin
                  pend_in = pend_dec;
                  case (item.mark.act)
                     ACT_SIMPLE: ;
                     ACT_PEND: begin
                        if (sum_ovf) begin
                           err = ST_OVF;
                        end else begin
                           pend_in = sum[PB-1:0];
                        end
                     end
                     ACT_PAY: begin
                        pay_left_in = PAYW'(item.mark.n);
                        phase_in    = (item.mark.n == 5'd0) ? PH_MARK : PH_PAY;
                     end
                     ACT_HEAD: begin
                        hdr_left_in = item.mark.hdr_bytes;
                        hdr_kind_in = item.mark.hdr_kind;
                        hdr_acc_in  = '0;
                        phase_in    = PH_HEAD;
                     end
                     default: err = ST_BAD;
                  endcase
               end
               PH_HEAD: begin
                  hdr_acc_in  = acc_n;
                  hdr_left_in = left_n;
                  if (left_n == 3'd0) begin
                     phase_in = PH_MARK;
                     if (too_long) begin
                        err = ST_OVF;
                     end else if (hdr_kind_ff == HK_STR || hdr_kind_ff == HK_EXT) begin
                        pay_left_in = hdr_pay;
                        phase_in    = (hdr_pay == '0) ? PH_MARK : PH_PAY;
                     end else if (sum_ovf) begin
                        err = ST_OVF;
                     end else begin
                        pend_in = sum[PB-1:0];
                     end
                  end
               end
               default: begin
                  pay_left_in = (pay_left_ff != '0) ? pay_left_ff - PAYW'(1) : pay_left_ff;
                  if (pay_left_in == '0) begin
                     phase_in = PH_MARK;
                  end
               end
            endcase

            if (err != ST_OK || (phase_in != PH_MARK || pend_in != '0) && item.eob) begin
               // error or truncation: report and clear all parser state
               res_valid   = 1'b1;
               res_status  = (err != ST_OK) ? err : ST_TRUNC;
               phase_in    = (err != ST_OK && !item.eob) ? PH_DROP : PH_MARK;
               hdr_left_in = '0;
               hdr_kind_in = '0;
               hdr_acc_in  = '0;
               pay_left_in = '0;
               pend_in     = '0;
               bcnt_in     = '0;
            end else if (phase_in == PH_MARK && pend_in == '0) begin
               res_valid  = 1'b1;
               res_status = ST_OK;
               bcnt_in    = '0;
            end
         end
      end
      res_bytes = bc_n;

      if (pop) begin
         out_valid_in = res_valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MARK;
         hdr_left_ff  <= '0;
         hdr_kind_ff  <= '0;
         hdr_acc_ff   <= '0;
         pay_left_ff  <= '0;
         pend_ff      <= '0;
         bcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_left_ff  <= hdr_left_in;
         hdr_kind_ff  <= hdr_kind_in;
         hdr_acc_ff   <= hdr_acc_in;
         pay_left_ff  <= pay_left_in;
         pend_ff      <= pend_in;
         bcnt_ff      <= bcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         out_bytes_ff  <= res_bytes;
         out_status_ff <= res_status;
         out_last_ff   <= item.eob;
      end
   end

endmodule

// ===== rtl/msgpack_value_skipper_core.sv =====
// Throughput: one byte per cycle sustained while rsp_tready does not hold results back,
//    a result at most once per byte. Path: the byte that ends a value is written to the
//    queue, then parsed into the output register that drives rsp_tvalid.
// A four-entry queue lets intake continue while the output register stalls.
// Reset: synchronous, active high; empties the queue, drops any held result
//    and returns the parser to expect a marker byte with no value open.
module msgpack_value_skipper_core #(
   parameter int PENDING_BITS = mvs_pkg::PENDING_BITS_DEF,
   parameter int LENGTH_BITS  = mvs_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value_bytes
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // at_buffer_end
);
   import mvs_pkg::*;

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     not_empty;
   item_type pop_item;

   mvs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   mvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   mvs_back #(
      .PENDING_BITS (PENDING_BITS),
      .LENGTH_BITS  (LENGTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (not_empty),
      .item       (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/mvs_checker.sv =====
module mvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import mvs_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready && (req_tdata == req_tdata) && (req_tlast == req_tlast);

   // a stalled result transfer keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // every result counts at least the byte that produced it
   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 32'd0)
      else $error("result with zero byte count");

   // truncation is only reported on the last byte of a buffer
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_TRUNC |-> rsp_tlast)
      else $error("truncated status without buffer end");

   // nothing is presented right after reset, nor straight after that unless a byte was accepted
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_result_needs_input: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_fire |=> !rsp_tvalid)
      else $error("result appeared without any accepted transfer");

endmodule

bind msgpack_value_skipper_core mvs_checker u_mvs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
